@@ hdl/b64_pkg.sv @@
// ----------------------------------------------------------------------------
// b64_pkg: shared types, constants and alphabet functions
// Result and job records passed from the front end through the job queue
// to the output serializer, plus the base64 character mapping.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int MAX_RES     = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 2'd1;

  // Characters
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_USCR  = 8'h5F;  // '_'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_D0    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_D9    = 8'h39;  // '9'

  localparam logic [5:0] SEXTET_62 = 6'd62;
  localparam logic [5:0] SEXTET_63 = 6'd63;

  typedef struct packed {
    logic [7:0] value;
    logic       has_data;
    logic       last;
    logic       error;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] cnt;
    res_t [MAX_RES-1:0]   res;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } qstat_t;

  // Map a 6-bit value to its character
  function automatic logic [7:0] sextet_char(logic [5:0] v, logic url);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UA + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LA + {2'b00, v} - 8'd26;
    end else if (v < SEXTET_62) begin
      c = CHAR_D0 + {2'b00, v} - 8'd52;
    end else if (v == SEXTET_62) begin
      c = url ? CHAR_DASH : CHAR_PLUS;
    end else begin
      c = url ? CHAR_USCR : CHAR_SLASH;
    end
    return c;
  endfunction

  // Map a url-alphabet character to {valid, 6-bit value}
  function automatic logic [6:0] char_sextet(logic [7:0] c);
    logic [6:0] r;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      r = {1'b1, 6'(c - CHAR_UA)};
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      r = {1'b1, 6'(c - CHAR_LA + 8'd26)};
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      r = {1'b1, 6'(c - CHAR_D0 + 8'd52)};
    end else if (c == CHAR_DASH) begin
      r = {1'b1, SEXTET_62};
    end else if (c == CHAR_USCR) begin
      r = {1'b1, SEXTET_63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

@@ hdl/b64_if.sv @@
// ----------------------------------------------------------------------------
// b64_if: channel interfaces of the codec
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic       last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic       has_data;
  logic       last;
  logic       error;
  modport source (output valid, output value, output has_data, output last,
                  output error, input ready);
  modport sink   (input valid, input value, input has_data, input last,
                  input error, output ready);
endinterface

interface b64_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/base64_stream_codec.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and url-alphabet decoder
// Results of an accepted item pass through the job queue and then the output register.
// Throughput: one input item per cycle while the job queue has room; one
// result per cycle at the output register while the output side is ready.
// Reset: synchronous active-low; clears configuration, message state,
// the job queue and the output register.
// ----------------------------------------------------------------------------
module base64_stream_codec
  import b64_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  b64_in_if.sink    in_s,
  b64_out_if.source out_s,
  b64_cfg_if.sink   cfg_s
);

  push_t  push;
  qstat_t qstat;
  job_t   head;
  logic   pop;

  b64_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .cfg_s (cfg_s),
    .qstat (qstat),
    .push  (push)
  );

  b64_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  b64_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .out_s (out_s)
  );

endmodule

@@ hdl/b64_front.sv @@
// ----------------------------------------------------------------------------
// b64_front: input front end
// Accepts items, updates the message state and builds one job holding all
// results that the item causes. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module b64_front
  import b64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  b64_in_if.sink   in_s,
  b64_cfg_if.sink  cfg_s,
  input  qstat_t   qstat,
  output push_t    push
);

  logic       direction_r, direction_nxt;
  logic       variant_r, variant_nxt;
  logic [5:0] carry_r, carry_nxt;
  logic [2:0] ccount_r, ccount_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       pad_r, pad_nxt;
  logic       err_r, err_nxt;

  logic       accept;
  logic       cfg_wr;
  job_t       job;
  logic [5:0] sx0, sx1;
  logic [7:0] ch0, ch1;
  logic [6:0] dec;
  logic [11:0] acc;
  logic [3:0] bits;
  logic [3:0] rem;
  logic       have_byte;
  logic [7:0] dbyte;
  logic [6:0] mask;
  logic       fin_err;

  assign in_s.ready  = !qstat.full;
  assign cfg_s.ready = 1'b1;
  assign accept      = in_s.valid && !qstat.full;
  assign cfg_wr      = cfg_s.valid;

  // Character lookups for the first two result slots, shared by all encode phases
  assign ch0 = sextet_char(sx0, variant_r);
  assign ch1 = sextet_char(sx1, variant_r);
  assign dec = char_sextet(in_s.value);

  // Decode carry arithmetic
  assign acc       = {carry_r, dec[5:0]};
  assign bits      = {1'b0, ccount_r} + 4'd6;
  assign have_byte = (bits >= 4'd8);
  assign rem       = have_byte ? bits - 4'd8 : bits;
  assign dbyte     = 8'(acc >> rem);
  assign mask      = 7'((8'd1 << rem) - 8'd1);

  // Build the job and next message state
  always_comb begin
    carry_nxt  = carry_r;
    ccount_nxt = ccount_r;
    phase_nxt  = phase_r;
    pad_nxt    = pad_r;
    err_nxt    = err_r;
    sx0        = '0;
    sx1        = '0;
    job        = '0;
    fin_err    = 1'b0;
    if (!direction_r) begin
      unique case (phase_r)
        2'd0: begin
          sx0 = in_s.value[7:2];
          sx1 = {in_s.value[1:0], 4'b0000};
          carry_nxt = {4'b0000, in_s.value[1:0]};
          phase_nxt = 2'd1;
          job.res[0] = '{value: ch0, has_data: 1'b1, last: 1'b0, error: 1'b0};
          job.res[1] = '{value: ch1, has_data: 1'b1, last: variant_r, error: 1'b0};
          job.res[2] = '{value: CHAR_PAD, has_data: 1'b1, last: 1'b0, error: 1'b0};
          job.res[3] = '{value: CHAR_PAD, has_data: 1'b1, last: 1'b1, error: 1'b0};
          job.cnt = !in_s.last ? RES_CNT_W'(1) :
                    (variant_r ? RES_CNT_W'(2) : RES_CNT_W'(4));
        end
        2'd1: begin
          sx0 = {carry_r[1:0], in_s.value[7:4]};
          sx1 = {in_s.value[3:0], 2'b00};
          carry_nxt = {2'b00, in_s.value[3:0]};
          phase_nxt = 2'd2;
          job.res[0] = '{value: ch0, has_data: 1'b1, last: 1'b0, error: 1'b0};
          job.res[1] = '{value: ch1, has_data: 1'b1, last: variant_r, error: 1'b0};
          job.res[2] = '{value: CHAR_PAD, has_data: 1'b1, last: 1'b1, error: 1'b0};
          job.cnt = !in_s.last ? RES_CNT_W'(1) :
                    (variant_r ? RES_CNT_W'(2) : RES_CNT_W'(3));
        end
        default: begin
          sx0 = {carry_r[3:0], in_s.value[7:6]};
          sx1 = in_s.value[5:0];
          carry_nxt = '0;
          phase_nxt = 2'd0;
          job.res[0] = '{value: ch0, has_data: 1'b1, last: 1'b0, error: 1'b0};
          job.res[1] = '{value: ch1, has_data: 1'b1, last: in_s.last, error: 1'b0};
          job.cnt = RES_CNT_W'(2);
        end
      endcase
    end else begin
      if (in_s.value == CHAR_PAD) begin
        pad_nxt = 1'b1;
      end else if (!dec[6] || pad_r) begin
        err_nxt = 1'b1;
      end else if (!err_r) begin
        carry_nxt  = acc[5:0] & mask[5:0];
        ccount_nxt = rem[2:0];
        phase_nxt  = phase_r + 2'd1;
      end
      // A byte exists only when the character was actually absorbed
      fin_err = err_nxt || (phase_nxt == 2'd1);
      if (in_s.last) begin
        job.cnt = RES_CNT_W'(1);
        if (have_byte && in_s.value != CHAR_PAD && dec[6] && !pad_r && !err_r) begin
          job.res[0] = '{value: dbyte, has_data: 1'b1, last: 1'b1, error: fin_err};
        end else begin
          job.res[0] = '{value: 8'd0, has_data: 1'b0, last: 1'b1, error: fin_err};
        end
      end else if (have_byte && in_s.value != CHAR_PAD && dec[6] && !pad_r && !err_r) begin
        job.cnt = RES_CNT_W'(1);
        job.res[0] = '{value: dbyte, has_data: 1'b1, last: 1'b0, error: 1'b0};
      end
    end
    // Drop the message state at the end of a message
    if (in_s.last) begin
      carry_nxt  = '0;
      ccount_nxt = '0;
      phase_nxt  = '0;
      pad_nxt    = 1'b0;
      err_nxt    = 1'b0;
    end
  end

  assign push.valid = accept && (job.cnt != '0);
  assign push.job   = job;

  // Configuration registers
  always_comb begin
    direction_nxt = direction_r;
    variant_nxt   = variant_r;
    if (cfg_wr && cfg_s.index == REG_DIRECTION) direction_nxt = cfg_s.data;
    if (cfg_wr && cfg_s.index == REG_VARIANT)   variant_nxt   = cfg_s.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      variant_r   <= 1'b0;
      carry_r     <= '0;
      ccount_r    <= '0;
      phase_r     <= '0;
      pad_r       <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      direction_r <= direction_nxt;
      variant_r   <= variant_nxt;
      if (cfg_wr && (cfg_s.index == REG_DIRECTION || cfg_s.index == REG_VARIANT)) begin
        carry_r  <= '0;
        ccount_r <= '0;
        phase_r  <= '0;
        pad_r    <= 1'b0;
        err_r    <= 1'b0;
      end else if (accept) begin
        carry_r  <= carry_nxt;
        ccount_r <= ccount_nxt;
        phase_r  <= phase_nxt;
        pad_r    <= pad_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

@@ hdl/b64_queue.sv @@
// ----------------------------------------------------------------------------
// b64_queue: job queue
// Short FIFO of jobs between the front end and the output serializer.
// ----------------------------------------------------------------------------
module b64_queue
  import b64_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output job_t   head,
  output qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head             = mem_r[rd_ptr_r];
  assign qstat.head_valid = (cnt_r != '0);
  assign qstat.full       = (cnt_r == FULL_CNT);

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push.valid && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!push.valid && pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hdl/b64_back.sv @@
// ----------------------------------------------------------------------------
// b64_back: output serializer
// Steps through the head job's results, one per cycle unless the output
// stalls, into the output register; pops the job after its final result.
// ----------------------------------------------------------------------------
module b64_back
  import b64_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  qstat_t    qstat,
  output logic      pop,
  b64_out_if.source out_s
);

  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 load;
  logic                 at_end;

  assign load   = qstat.head_valid && (!out_valid_r || out_s.ready);
  assign at_end = (RES_CNT_W'(idx_r) + RES_CNT_W'(1)) == head.cnt;
  assign pop    = load && at_end;

  // Advance through the job's results
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = at_end ? '0 : idx_r + RES_IDX_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= head.res[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_s.valid    = out_valid_r;
  assign out_s.value    = out_r.value;
  assign out_s.has_data = out_r.has_data;
  assign out_s.last     = out_r.last;
  assign out_s.error    = out_r.error;

endmodule

@@ hdl/b64_checker.sv @@
// ----------------------------------------------------------------------------
// b64_checker: port-level checks of the codec's result channel
// Watches the result channel and flags malformed transactions.
// ----------------------------------------------------------------------------
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value,
  input logic       out_has_data,
  input logic       out_last,
  input logic       out_error
);

  // Hold a stalled transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  // Error flag only on a final result
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error on non-final result");

  // End-only result is final and carries zero
  a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last && out_value == 8'd0)
    else $error("malformed end-only result");

  // No transaction right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind base64_stream_codec b64_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_s.valid),
  .out_ready    (out_s.ready),
  .out_value    (out_s.value),
  .out_has_data (out_s.has_data),
  .out_last     (out_s.last),
  .out_error    (out_s.error)
);

@@ verif/base64_stream_codec_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_codec_test: self-checking testbench for the base64 stream codec
// Walks a short table of directed transactions (alphabet extremes, padding,
// decode error cases), then random messages in every mode. Random messages
// are mostly well-formed, with some broken ones and some noise. Both sides
// idle at random, and the output side holds off once for a long stretch.
// Each result is checked against listed results or a local model of the codec.
// ----------------------------------------------------------------------------
module base64_stream_codec_test;
  import b64_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic DIR_ENCODE  = 1'b0;
  localparam logic DIR_DECODE  = 1'b1;
  localparam logic VARIANT_STD = 1'b0;
  localparam logic VARIANT_URL = 1'b1;

  // Which registers a configuration step writes
  localparam logic [1:0] WR_DIR     = 2'b01;
  localparam logic [1:0] WR_VARIANT = 2'b10;
  localparam logic [1:0] WR_BOTH    = 2'b11;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef enum int {
    MSG_CLEAN,
    MSG_BAD_CHAR,
    MSG_DATA_AFTER_PAD,
    MSG_SHORT_GROUP,
    MSG_NOISE
  } dec_msg_e;

  typedef struct {
    row_kind_e          kind;
    logic [7:0]         value;
    logic               last;
    logic [1:0]         wr_mask;
    logic               dir;
    logic               variant;
    int                 n_known;
    res_t [MAX_RES-1:0] known;
  } row_t;

  string std_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string url_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  b64_in_if  in_ch ();
  b64_out_if out_ch ();
  b64_cfg_if cfg_ch ();

  base64_stream_codec i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Codec model state
  logic       mode_decode;
  logic       url_variant;
  logic [5:0] carry_bits;
  logic [2:0] carry_count;
  logic [1:0] group_phase;
  logic       pad_seen;
  logic       error_seen;

  res_t step_results[$];
  res_t pending_results[$];

  logic send_burst    = 1'b0;
  int   error_count   = 0;
  int   results_seen  = 0;
  int   invalid_flags = 0;
  int   enc_items     = 0;
  int   dec_items     = 0;
  int   messages      = 0;
  int   cycle_count   = 0;

  function automatic res_t mk_res(logic [7:0] value, logic has_data, logic last,
                                  logic error);
    res_t r;
    r.value    = value;
    r.has_data = has_data;
    r.last     = last;
    r.error    = error;
    return r;
  endfunction

  function automatic void clear_message();
    carry_bits  = '0;
    carry_count = '0;
    group_phase = '0;
    pad_seen    = 1'b0;
    error_seen  = 1'b0;
  endfunction

  function automatic logic [7:0] enc_char(logic [5:0] s);
    return url_variant ? url_alphabet[s] : std_alphabet[s];
  endfunction

  // Return {valid, sextet} for a url-alphabet character
  function automatic logic [6:0] url_lookup(logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (url_alphabet[i] == c) return {1'b1, 6'(i)};
    end
    return 7'd0;
  endfunction

  // Advance the model by one input transaction; fill step_results
  function automatic void predict_step(logic [7:0] v, logic last);
    logic [6:0]  sx;
    logic [11:0] acc;
    logic [3:0]  nbits;
    logic        have;
    logic [7:0]  data;
    step_results.delete();
    have = 1'b0;
    data = 8'h00;
    if (!mode_decode) begin
      case (group_phase)
        2'd0: begin
          step_results.push_back(mk_res(enc_char(v[7:2]), 1'b1, 1'b0, 1'b0));
          carry_bits  = {4'd0, v[1:0]};
          group_phase = 2'd1;
          if (last) begin
            step_results.push_back(mk_res(enc_char({carry_bits[1:0], 4'd0}), 1'b1,
                                          url_variant, 1'b0));
            if (!url_variant) begin
              step_results.push_back(mk_res(CHAR_PAD, 1'b1, 1'b0, 1'b0));
              step_results.push_back(mk_res(CHAR_PAD, 1'b1, 1'b1, 1'b0));
            end
          end
        end
        2'd1: begin
          step_results.push_back(mk_res(enc_char({carry_bits[1:0], v[7:4]}), 1'b1,
                                        1'b0, 1'b0));
          carry_bits  = {2'd0, v[3:0]};
          group_phase = 2'd2;
          if (last) begin
            step_results.push_back(mk_res(enc_char({carry_bits[3:0], 2'd0}), 1'b1,
                                          url_variant, 1'b0));
            if (!url_variant) step_results.push_back(mk_res(CHAR_PAD, 1'b1, 1'b1, 1'b0));
          end
        end
        default: begin
          step_results.push_back(mk_res(enc_char({carry_bits[3:0], v[7:6]}), 1'b1,
                                        1'b0, 1'b0));
          step_results.push_back(mk_res(enc_char(v[5:0]), 1'b1, last, 1'b0));
          carry_bits  = '0;
          group_phase = 2'd0;
        end
      endcase
      if (last) clear_message();
    end else begin
      if (v == CHAR_PAD) begin
        pad_seen = 1'b1;
      end else begin
        sx = url_lookup(v);
        if (!sx[6] || pad_seen) begin
          error_seen = 1'b1;
        end else if (!error_seen) begin
          // shift the sextet in; take a byte once eight bits have gathered
          acc   = {carry_bits, sx[5:0]};
          nbits = 4'(carry_count) + 4'd6;
          if (nbits >= 4'd8) begin
            nbits = nbits - 4'd8;
            data  = 8'(acc >> nbits);
            have  = 1'b1;
          end
          carry_bits  = 6'(acc & ((12'd1 << nbits) - 12'd1));
          carry_count = 3'(nbits);
          group_phase = group_phase + 2'd1;
        end
      end
      if (last) begin
        step_results.push_back(mk_res(have ? data : 8'h00, have, 1'b1,
                                      error_seen || group_phase == 2'd1));
        clear_message();
      end else if (have) begin
        step_results.push_back(mk_res(data, 1'b1, 1'b0, 1'b0));
      end
    end
  endfunction

  // Draw an idle count; toggle now and then into a stretch without idling
  function automatic int draw_gap(inout logic burst);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [6:0] sx;
    case ($urandom_range(0, 3))
      0:       c = CHAR_PLUS;
      1:       c = CHAR_SLASH;
      2:       c = 8'($urandom_range(128, 255));
      default: begin
        do begin
          c  = 8'($urandom_range(0, 127));
          sx = url_lookup(c);
        end while (sx[6] || c == CHAR_PAD);
      end
    endcase
    return c;
  endfunction

  function automatic row_t item_row(logic [7:0] value, logic last, int n_known = -1,
                                    res_t e0 = '0, res_t e1 = '0, res_t e2 = '0,
                                    res_t e3 = '0);
    row_t r;
    r.kind     = ROW_ITEM;
    r.value    = value;
    r.last     = last;
    r.wr_mask  = '0;
    r.dir      = DIR_ENCODE;
    r.variant  = VARIANT_STD;
    r.n_known  = n_known;
    r.known[0] = e0;
    r.known[1] = e1;
    r.known[2] = e2;
    r.known[3] = e3;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] wr_mask, logic dir, logic variant);
    row_t r;
    r         = item_row(8'h00, 1'b0);
    r.kind    = ROW_CFG;
    r.wr_mask = wr_mask;
    r.dir     = dir;
    r.variant = variant;
    return r;
  endfunction

  // Offer one input transaction after a random gap; predict on acceptance
  task automatic send_item(input logic [7:0] v, input logic last, input int n_known = -1,
                           input res_t [MAX_RES-1:0] known = '0);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (mode_decode) dec_items++;
    else enc_items++;
    if (last) messages++;
    predict_step(v, last);
    if (n_known >= 0) begin
      for (int i = 0; i < n_known; i++) pending_results.push_back(known[i]);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Drop the input valid and drain every expected result before a register write
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [1:0] wr_mask, input logic dir,
                            input logic variant);
    if (wr_mask[0]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= REG_DIRECTION;
      cfg_ch.data  <= dir;
      do @(posedge clk); while (!cfg_ch.ready);
      mode_decode = dir;
      clear_message();
    end
    if (wr_mask[1]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= REG_VARIANT;
      cfg_ch.data  <= variant;
      do @(posedge clk); while (!cfg_ch.ready);
      url_variant = variant;
      clear_message();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_encode_message();
    int nbytes;
    nbytes = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                         : int'($urandom_range(1, 9));
    for (int i = 0; i < nbytes; i++) send_item(rand_byte(), i == nbytes - 1);
  endtask

  // Build a url-alphabet message (mostly well-formed) and send it
  task automatic send_decode_message();
    logic [7:0] chars[$];
    dec_msg_e   kind;
    int         pick;
    int         nbytes;
    int         acc;
    int         nbits;
    int         data_len;
    int         keep;
    pick = $urandom_range(0, 19);
    kind = pick < 13 ? MSG_CLEAN : pick < 15 ? MSG_BAD_CHAR :
           pick < 17 ? MSG_DATA_AFTER_PAD : pick < 19 ? MSG_SHORT_GROUP : MSG_NOISE;
    nbytes = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 30))
                                         : int'($urandom_range(1, 6));
    acc   = 0;
    nbits = 0;
    repeat (nbytes) begin
      acc   = (acc << 8) | int'(rand_byte());
      nbits = nbits + 8;
      while (nbits >= 6) begin
        nbits = nbits - 6;
        chars.push_back(url_alphabet[(acc >> nbits) & 63]);
      end
      acc = acc & ((1 << nbits) - 1);
    end
    if (nbits > 0) chars.push_back(url_alphabet[(acc << (6 - nbits)) & 63]);
    data_len = chars.size();

    // break the message where asked, then add optional padding
    case (kind)
      MSG_SHORT_GROUP: begin
        keep  = 4 * int'($urandom_range(0, (data_len - 1) / 4)) + 1;
        chars = chars[0:keep-1];
      end
      MSG_NOISE: begin
        chars.delete();
        repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        if (kind == MSG_DATA_AFTER_PAD) begin
          chars.insert($urandom_range(0, data_len - 1), CHAR_PAD);
        end
        if ($urandom_range(0, 1) == 1) begin
          repeat ((3 - nbytes % 3) % 3) chars.push_back(CHAR_PAD);
        end
        if (kind == MSG_BAD_CHAR) chars.insert($urandom_range(0, chars.size()), bad_char());
      end
    endcase
    foreach (chars[i]) send_item(chars[i], i == chars.size() - 1);
  endtask

  // Result side: random stalls, one long hold-off to back up the block
  initial begin : result_sink
    int   stall;
    logic burst;
    bit   held;
    burst = 1'b0;
    held  = 1'b0;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = draw_gap(burst);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.error) invalid_flags++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h has_data %b last %b error %b",
               out_ch.value, out_ch.has_data, out_ch.last, out_ch.error);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_ch.value);
          error_count++;
        end
        if (out_ch.has_data !== want.has_data) begin
          $error("out_has_data: expected %b, got %b", want.has_data, out_ch.has_data);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_ch.last);
          error_count++;
        end
        if (out_ch.error !== want.error) begin
          $error("out_error: expected %b, got %b", want.error, out_ch.error);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("base64_stream_codec_test: timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("base64_stream_codec_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    row_t       rows[$];
    logic       dir;
    logic       variant;
    logic [1:0] wr_mask;
    int         phase_start;

    in_ch.valid  = 1'b0;
    in_ch.value  = 8'h00;
    in_ch.last   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DIRECTION;
    cfg_ch.data  = 1'b0;
    mode_decode  = DIR_ENCODE;
    url_variant  = VARIANT_STD;
    clear_message();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Encode, standard alphabet out of reset: padding after one byte and two bytes
    rows.push_back(item_row(8'h00, 1'b1, 4,
                            mk_res("A", 1'b1, 1'b0, 1'b0),
                            mk_res("A", 1'b1, 1'b0, 1'b0),
                            mk_res(CHAR_PAD, 1'b1, 1'b0, 1'b0),
                            mk_res(CHAR_PAD, 1'b1, 1'b1, 1'b0)));
    rows.push_back(item_row(8'hFF, 1'b0, 1, mk_res(CHAR_SLASH, 1'b1, 1'b0, 1'b0)));
    rows.push_back(item_row(8'hFF, 1'b1, 3,
                            mk_res(CHAR_SLASH, 1'b1, 1'b0, 1'b0),
                            mk_res("8", 1'b1, 1'b0, 1'b0),
                            mk_res(CHAR_PAD, 1'b1, 1'b1, 1'b0)));
    // Encode, url alphabet: top sextets, no padding
    rows.push_back(cfg_row(WR_VARIANT, DIR_ENCODE, VARIANT_URL));
    rows.push_back(item_row(8'hFB, 1'b0, 1, mk_res(CHAR_DASH, 1'b1, 1'b0, 1'b0)));
    rows.push_back(item_row(8'hFF, 1'b1, 2,
                            mk_res(CHAR_USCR, 1'b1, 1'b0, 1'b0),
                            mk_res("8", 1'b1, 1'b1, 1'b0)));
    rows.push_back(item_row(8'h80, 1'b1));
    // Decode: a full group, an all-ones byte, a padded group and each error case
    rows.push_back(cfg_row(WR_DIR, DIR_DECODE, VARIANT_URL));
    rows.push_back(item_row("T", 1'b0));
    rows.push_back(item_row("W", 1'b0));
    rows.push_back(item_row("F", 1'b0));
    rows.push_back(item_row("u", 1'b1));
    rows.push_back(item_row(CHAR_USCR, 1'b0, 0));
    rows.push_back(item_row("w", 1'b1, 1, mk_res(8'hFF, 1'b1, 1'b1, 1'b0)));
    rows.push_back(item_row("A", 1'b1, 1, mk_res(8'h00, 1'b0, 1'b1, 1'b1)));
    rows.push_back(item_row(CHAR_PLUS, 1'b1, 1, mk_res(8'h00, 1'b0, 1'b1, 1'b1)));
    rows.push_back(item_row(8'hFF, 1'b1, 1, mk_res(8'h00, 1'b0, 1'b1, 1'b1)));
    rows.push_back(item_row("Q", 1'b0));
    rows.push_back(item_row("Q", 1'b0));
    rows.push_back(item_row(CHAR_PAD, 1'b0));
    rows.push_back(item_row(CHAR_PAD, 1'b1));
    rows.push_back(item_row("A", 1'b0));
    rows.push_back(item_row("B", 1'b0));
    rows.push_back(item_row(CHAR_PAD, 1'b0));
    rows.push_back(item_row("C", 1'b1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_regs(rows[i].wr_mask, rows[i].dir, rows[i].variant);
      end else begin
        send_item(rows[i].value, rows[i].last, rows[i].n_known, rows[i].known);
      end
    end

    // Random messages: every mode combination first, then random settings
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        dir     = p[1];
        variant = p[0];
        wr_mask = WR_BOTH;
      end else begin
        dir     = 1'($urandom_range(0, 1));
        variant = 1'($urandom_range(0, 1));
        wr_mask = 2'($urandom_range(1, 3));
      end
      settle();
      write_regs(wr_mask, dir, variant);
      phase_start = enc_items + dec_items;
      while (enc_items + dec_items - phase_start < PHASE_ITEMS) begin
        if (mode_decode) send_decode_message();
        else send_encode_message();
      end
    end
    settle();

    $display("base64_stream_codec_test: %0d encode and %0d decode transactions, %0d messages",
             enc_items, dec_items, messages);
    $display("base64_stream_codec_test: %0d results checked, %0d marked invalid",
             results_seen, invalid_flags);
    if (error_count == 0) begin
      $display("base64_stream_codec_test: done, clean");
    end else begin
      $display("base64_stream_codec_test: done, errors");
    end
    $finish;
  end

endmodule

@@ base64_stream_codec.f @@
hdl/b64_pkg.sv
hdl/b64_if.sv
hdl/b64_front.sv
hdl/b64_queue.sv
hdl/b64_back.sv
hdl/base64_stream_codec.sv
hdl/b64_checker.sv
verif/base64_stream_codec_test.sv
